// ===== rtl/tdf_pkg.sv =====
// Shared types and constants for the trial-division factorizer.
// No dependencies; used by scoped name in every module of the block but the divider.
package tdf_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;       // take req_value as remaining value, divisor back to two
      logic div_start;  // start remaining / divisor
      logic take_q;     // remaining value <= quotient
      logic inc_d;      // advance divisor
      logic emit;       // write one factor into the output register
      logic sel_rem;    // factor is the remaining value instead of the divisor
      logic last;       // marker for the factor written
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic value_small;  // req_value below two
      logic div_done;     // divider idle, quotient and remainder hold
      logic r_zero;       // divisor divides evenly
      logic d_gt_q;       // divisor above quotient: square exceeds remaining value
      logic q_one;        // quotient is one
      logic rem_gt1;      // remaining value above one
      logic out_free;     // output register can take a factor this cycle
   } status_type;

endpackage

// ===== rtl/tdf_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the factorizer datapath.
// Depends on nothing but its parameter.
module tdf_divider #(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quot,
   output logic [VALUE_BITS-1:0] remd
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic                  run_ff, run_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [VALUE_BITS:0]   shifted;
   logic [VALUE_BITS:0]   trial;

   always_comb begin
      shifted = {acc_ff, quo_ff[VALUE_BITS-1]};
      trial   = shifted - {1'b0, dvs_ff};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(VALUE_BITS);
         acc_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         // keep the partial remainder only when the trial subtract does not borrow
         if (!trial[VALUE_BITS]) begin
            acc_in = trial[VALUE_BITS-1:0];
         end else begin
            acc_in = shifted[VALUE_BITS-1:0];
         end
         quo_in = {quo_ff[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = ~run_ff;
   assign quot = quo_ff;
   assign remd = acc_ff;

endmodule

// ===== rtl/tdf_datapath.sv =====
// Datapath of the factorizer: remaining value, divisor, divider and output register.
// Depends on tdf_pkg and tdf_divider.
module tdf_datapath #(
   parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] req_value,
   input  tdf_pkg::cmd_type      cmd,
   output tdf_pkg::status_type   status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_factor,
   output logic                  rsp_last
);

   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] factor_ff, factor_in;
   logic                  last_ff, last_in;
   logic                  div_done;
   logic [VALUE_BITS-1:0] quot;
   logic [VALUE_BITS-1:0] remd;

   tdf_divider #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(rem_ff),
      .divisor (d_ff),
      .done    (div_done),
      .quot    (quot),
      .remd    (remd)
   );

   always_comb begin
      rem_in    = rem_ff;
      d_in      = d_ff;
      factor_in = factor_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         rem_in = req_value;
         d_in   = VALUE_BITS'(2);
      end
      if (cmd.take_q) begin
         rem_in = quot;
      end
      if (cmd.inc_d) begin
         d_in = d_ff + VALUE_BITS'(1);
      end
      // drop the held factor once transferred, load a new one on emit
      valid_in = valid_ff & rsp_stall;
      if (cmd.emit) begin
         valid_in  = 1'b1;
         factor_in = cmd.sel_rem ? rem_ff : d_ff;
         last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      factor_ff <= factor_in;
      last_ff   <= last_in;
   end

   always_comb begin
      status.value_small = req_value < VALUE_BITS'(2);
      status.div_done    = div_done;
      status.r_zero      = remd == '0;
      status.d_gt_q      = d_ff > quot;
      status.q_one       = quot == VALUE_BITS'(1);
      status.rem_gt1     = rem_ff > VALUE_BITS'(1);
      status.out_free    = ~valid_ff | ~rsp_stall;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_factor = factor_ff;
   assign rsp_last   = last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("factor emitted while output register still held");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> div_done)
      else $error("divider restarted while busy");

   a_factor_min: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> factor_ff >= VALUE_BITS'(2))
      else $error("factor below two");

   a_no_mix: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !cmd.div_start && !cmd.inc_d && !cmd.load)
      else $error("emit combined with a divisor step");

endmodule

// ===== rtl/tdf_ctrl.sv =====
// Controller state machine of the factorizer: sequences divisions and emits factors.
// Depends on tdf_pkg.
module tdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tdf_pkg::status_type status,
   output tdf_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_EVAL  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       chk_ff, chk_in;  // test the divisor bound before the next even-division test

   always_comb begin
      state_in = state_ff;
      chk_in   = chk_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               chk_in   = 1'b1;
               if (!status.value_small) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (chk_ff && status.d_gt_q) begin
               // divisor squared exceeds the remaining value: it is prime or one
               if (!status.rem_gt1) begin
                  state_in = ST_IDLE;
               end else if (status.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.sel_rem = 1'b1;
                  cmd.last    = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (status.r_zero) begin
               if (status.out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.last   = status.q_one;
                  cmd.take_q = 1'b1;
                  chk_in     = 1'b0;
                  state_in   = status.q_one ? ST_IDLE : ST_START;
               end
            end else begin
               cmd.inc_d = 1'b1;
               chk_in    = 1'b1;
               state_in  = ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= chk_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE)
      else $error("value loaded outside idle");

   a_div_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == ST_DIV && !status.div_done)
      else $error("divider did not start");

   a_eval_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> status.div_done)
      else $error("evaluation with divider busy");

endmodule

// ===== rtl/trial_division_factorizer.sv =====
// Top level of the trial-division factorizer: controller plus datapath.
// Depends on tdf_pkg, tdf_ctrl and tdf_datapath.
//
// Takes one positive integer per req_ transfer and returns its prime factors in
// ascending order, with repetition, one per rsp_ transfer; rsp_last marks the
// final factor, and an input of one returns nothing. One item is worked at a
// time. Each trial divisor costs one division in a shared restoring divider,
// started in ST_START, awaited in ST_DIV and judged in ST_EVAL. A new value
// is taken while the last factor still waits in the output register.
module trial_division_factorizer #(
   parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_factor,
   output logic                  rsp_last
);

   tdf_pkg::cmd_type    cmd;
   tdf_pkg::status_type status;

   tdf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   tdf_datapath #(
      .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_value),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_factor(rsp_factor),
      .rsp_last  (rsp_last)
   );

endmodule
